// ===== rtl/sta_pkg.sv =====
// Shared types, constants and arithmetic steps for the spherical triangle solid angle block.
// No dependencies; imported by sta_isqrt, sta_cordic and spherical_triangle_solid_angle.
package sta_pkg;

  // pipeline depth: stage 0 takes the input beat, the last stage is the output register
  localparam int NSTG     = 23;
  localparam int OUT_STG  = NSTG - 1;

  // angles with 30 fraction bits
  localparam logic [32:0] PI_Q30      = 33'd3373259426;
  localparam logic [32:0] HALF_PI_Q30 = 33'd1686629713;
  localparam logic [32:0] ROUND_HALF  = 33'd4096;

  // square root recurrence state
  typedef struct packed {
    logic [63:0] rem;
    logic [63:0] root;
  } sqrt_t;

  // CORDIC vector and angle
  typedef struct packed {
    logic signed [33:0] x;
    logic signed [33:0] y;
    logic signed [33:0] z;
  } cordic_t;

  // arctangent of 2^-i, 30 fraction bits, truncated
  function automatic logic signed [33:0] atan_step(input int i);
    logic signed [33:0] r;
    case (i)
      0: r = 34'sd843314856;
      1: r = 34'sd497837829;
      2: r = 34'sd263043836;
      3: r = 34'sd133525158;
      4: r = 34'sd67021686;
      5: r = 34'sd33543515;
      6: r = 34'sd16775850;
      7: r = 34'sd8388437;
      8: r = 34'sd4194282;
      9: r = 34'sd2097149;
      default: r = $signed(34'((64'd1 << (30 - i)) - 64'd1));
    endcase
    return r;
  endfunction

  // one digit of the bitwise square root, j counts from the top digit
  function automatic sqrt_t sqrt_iter(input sqrt_t s, input int j);
    sqrt_t       r;
    logic [63:0] bitv;
    logic [63:0] trial;
    bitv  = 64'd1 << (62 - 2 * j);
    trial = s.root + bitv;
    r = s;
    if (s.rem >= trial) begin
      r.rem  = s.rem - trial;
      r.root = (s.root >> 1) + bitv;
    end else begin
      r.root = s.root >> 1;
    end
    return r;
  endfunction

  // one vectoring rotation
  function automatic cordic_t cordic_iter(input cordic_t c, input int i);
    cordic_t            r;
    logic signed [33:0] xs;
    logic signed [33:0] ys;
    xs = c.x >>> i;
    ys = c.y >>> i;
    if (c.y > 0) begin
      r.x = c.x + ys;
      r.y = c.y - xs;
      r.z = c.z + atan_step(i);
    end else begin
      r.x = c.x - ys;
      r.y = c.y + xs;
      r.z = c.z - atan_step(i);
    end
    return r;
  endfunction

endpackage

// ===== rtl/sta_isqrt.sv =====
// Pipelined rounded square root of (sq * 2^28): eight stages of four digits, one rounding stage.
// Depends on sta_pkg (sqrt_t, sqrt_iter).
module sta_isqrt (
  input  logic        clk,
  input  logic [8:0]  en,
  input  logic [35:0] sq,
  output logic [32:0] root
);
  import sta_pkg::*;

  sqrt_t st   [8];
  sqrt_t nxt  [8];

  // four digits per stage
  always_comb begin
    sqrt_t t;
    for (int k = 0; k < 8; k++) begin
      if (k == 0) begin
        t.rem  = {sq, 28'd0};
        t.root = 64'd0;
      end else begin
        t = st[k-1];
      end
      for (int j = 0; j < 4; j++) begin
        t = sqrt_iter(t, 4 * k + j);
      end
      nxt[k] = t;
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < 8; k++) begin
      if (en[k]) begin
        st[k] <= nxt[k];
      end
    end
    // round half up on the remainder
    if (en[8]) begin
      root <= (st[7].rem > st[7].root) ? st[7].root[32:0] + 33'd1 : st[7].root[32:0];
    end
  end

endmodule

// ===== rtl/sta_cordic.sv =====
// Pipelined 30-step vectoring CORDIC: six stages of five rotations, angle out with 30 fraction bits.
// Depends on sta_pkg (cordic_t, cordic_iter).
module sta_cordic (
  input  logic               clk,
  input  logic [5:0]         en,
  input  logic [29:0]        x0,
  input  logic [29:0]        y0,
  output logic signed [33:0] z
);
  import sta_pkg::*;

  cordic_t st  [6];
  cordic_t nxt [6];

  // five rotations per stage
  always_comb begin
    cordic_t t;
    for (int k = 0; k < 6; k++) begin
      if (k == 0) begin
        t.x = $signed({4'd0, x0});
        t.y = $signed({4'd0, y0});
        t.z = '0;
      end else begin
        t = st[k-1];
      end
      for (int j = 0; j < 5; j++) begin
        t = cordic_iter(t, 5 * k + j);
      end
      nxt[k] = t;
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < 6; k++) begin
      if (en[k]) begin
        st[k] <= nxt[k];
      end
    end
  end

  assign z = st[5].z;

endmodule

// ===== rtl/spherical_triangle_solid_angle.sv =====
// Solid angle of a triangle seen from the origin, 2*atan2(|(AxB).C|, denominator), unsigned Q16.
// Depends on sta_pkg, sta_isqrt and sta_cordic.

// One triangle enters per cycle while in_stall is low, and its result is presented on the output from
// the last stage's register; every stage holds its own valid bit and only stops when the stage after
// it is full, so bubbles close up under a stall.
// The depth is set by the three 32-digit square roots (nine stages), the 30-step CORDIC (six
// stages) and the wide denominator build and normalizing shift in between.
module spherical_triangle_solid_angle (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [17:0] a_x,
  input  logic signed [17:0] a_y,
  input  logic signed [17:0] a_z,
  input  logic signed [17:0] b_x,
  input  logic signed [17:0] b_y,
  input  logic signed [17:0] b_z,
  input  logic signed [17:0] c_x,
  input  logic signed [17:0] c_y,
  input  logic signed [17:0] c_z,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [18:0]        solid_angle
);
  import sta_pkg::*;

  logic [NSTG-1:0] vld;
  logic [NSTG-1:0] rdy;

  // stage ready chain: a stage loads when empty or when the next one loads
  always_comb begin
    rdy[OUT_STG] = !vld[OUT_STG] || !out_stall;
    for (int k = OUT_STG - 1; k >= 0; k--) begin
      rdy[k] = !vld[k] || rdy[k+1];
    end
  end

  assign in_stall  = !rdy[0];
  assign out_valid = vld[OUT_STG];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (rdy[0]) vld[0] <= in_valid;
      for (int k = 1; k < NSTG; k++) begin
        if (rdy[k]) vld[k] <= vld[k-1];
      end
    end
  end

  // stage 0: cross product, squared lengths, dot products
  logic signed [36:0] kx, ky, kz;
  logic signed [17:0] cx, cy, cz;
  logic [35:0]        sa, sb, sc;
  logic signed [36:0] ab_q [0:9];
  logic signed [36:0] ac_q [0:9];
  logic signed [36:0] bc_q [0:9];

  logic signed [35:0] p_aybz, p_azby, p_azbx, p_axbz, p_axby, p_aybx;
  logic signed [35:0] p_axbx, p_azbz, p_axcx, p_aycy, p_azcz, p_bxcx, p_bycy, p_bzcz;
  logic signed [37:0] sa_w, sb_w, sc_w;

  always_comb begin
    p_aybz = a_y * b_z;
    p_azby = a_z * b_y;
    p_azbx = a_z * b_x;
    p_axbz = a_x * b_z;
    p_axby = a_x * b_y;
    p_aybx = a_y * b_x;
    p_axbx = a_x * b_x;
    p_azbz = a_z * b_z;
    p_axcx = a_x * c_x;
    p_aycy = a_y * c_y;
    p_azcz = a_z * c_z;
    p_bxcx = b_x * c_x;
    p_bycy = b_y * c_y;
    p_bzcz = b_z * c_z;
    sa_w   = 38'(a_x * a_x) + 38'(a_y * a_y) + 38'(a_z * a_z);
    sb_w   = 38'(b_x * b_x) + 38'(b_y * b_y) + 38'(b_z * b_z);
    sc_w   = 38'(c_x * c_x) + 38'(c_y * c_y) + 38'(c_z * c_z);
  end

  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      kx      <= p_aybz - p_azby;
      ky      <= p_azbx - p_axbz;
      kz      <= p_axby - p_aybx;
      cx      <= c_x;
      cy      <= c_y;
      cz      <= c_z;
      sa      <= sa_w[35:0];
      sb      <= sb_w[35:0];
      sc      <= sc_w[35:0];
      ab_q[0] <= p_axbx + 37'(a_y * b_y) + p_azbz;
      ac_q[0] <= p_axcx + p_aycy + p_azcz;
      bc_q[0] <= p_bxcx + p_bycy + p_bzcz;
    end
  end

  // dot products ride along to the dot-times-length stage (stage 10)
  always_ff @(posedge clk) begin
    for (int k = 1; k < 10; k++) begin
      if (rdy[k]) begin
        ab_q[k] <= ab_q[k-1];
        ac_q[k] <= ac_q[k-1];
        bc_q[k] <= bc_q[k-1];
      end
    end
  end

  // stage 1: triple product; stage 2: its magnitude, carried to stage 12
  logic signed [55:0] det;
  logic [54:0]        num_q [2:12];

  always_ff @(posedge clk) begin
    if (rdy[1]) begin
      det <= kx * cx + ky * cy + kz * cz;
    end
    if (rdy[2]) begin
      num_q[2] <= det[55] ? 55'(-det) : det[54:0];
    end
    for (int k = 3; k < 13; k++) begin
      if (rdy[k]) num_q[k] <= num_q[k-1];
    end
  end

  // stages 1..9: vertex lengths with 14 fraction bits
  logic [32:0] na, nb, nc;

  sta_isqrt u_sqrt_a (.clk(clk), .en(rdy[9:1]), .sq(sa), .root(na));
  sta_isqrt u_sqrt_b (.clk(clk), .en(rdy[9:1]), .sq(sb), .root(nb));
  sta_isqrt u_sqrt_c (.clk(clk), .en(rdy[9:1]), .sq(sc), .root(nc));

  // stage 10: length product and dot-times-length magnitudes
  logic [63:0] pnn;
  logic [32:0] nc10;
  logic [68:0] tab, tac, tbc;
  logic        sab, sac, sbc;
  logic [35:0] mab, mac, mbc;
  logic [65:0] pnn_w;

  always_comb begin
    mab   = ab_q[9][36] ? 36'(-ab_q[9]) : ab_q[9][35:0];
    mac   = ac_q[9][36] ? 36'(-ac_q[9]) : ac_q[9][35:0];
    mbc   = bc_q[9][36] ? 36'(-bc_q[9]) : bc_q[9][35:0];
    pnn_w = na * nb;
  end

  always_ff @(posedge clk) begin
    if (rdy[10]) begin
      pnn  <= pnn_w[63:0];
      nc10 <= nc;
      tab  <= mab * nc;
      tac  <= mac * nb;
      tbc  <= mbc * na;
      sab  <= ab_q[9][36];
      sac  <= ac_q[9][36];
      sbc  <= bc_q[9][36];
    end
  end

  // stage 11: split triple-length product, signed sum of dot terms
  logic [64:0]        plo, phi;
  logic signed [71:0] dsum;
  logic signed [71:0] vab, vac, vbc;

  always_comb begin
    vab = sab ? -$signed({3'd0, tab}) : $signed({3'd0, tab});
    vac = sac ? -$signed({3'd0, tac}) : $signed({3'd0, tac});
    vbc = sbc ? -$signed({3'd0, tbc}) : $signed({3'd0, tbc});
  end

  always_ff @(posedge clk) begin
    if (rdy[11]) begin
      plo  <= pnn[31:0] * nc10;
      phi  <= pnn[63:32] * nc10;
      dsum <= vab + vac + vbc;
    end
  end

  // stage 12: denominator with 42 fraction bits
  logic signed [100:0] den;

  always_ff @(posedge clk) begin
    if (rdy[12]) begin
      den <= $signed({4'd0, phi, 32'd0}) + $signed({36'd0, plo})
           + $signed({dsum[71], dsum, 28'd0});
    end
  end

  // stage 13: magnitudes; stage 14: leading-one position; stage 15: normalize to 30 bits
  logic [99:0] dmag13, nmag13, dmag14, nmag14;
  logic        dneg_q [13:21];
  logic        zero_q [14:21];
  logic [6:0]  sh;
  logic [6:0]  len;
  logic [99:0] lead;
  logic [99:0] xsh, ysh;
  logic [29:0] x0, y0;

  always_comb begin
    lead = dmag13 | nmag13;
    len  = '0;
    for (int i = 0; i < 100; i++) begin
      if (lead[i]) len = 7'(i + 1);
    end
    xsh = dmag14 << sh;
    ysh = nmag14 << sh;
  end

  always_ff @(posedge clk) begin
    if (rdy[13]) begin
      dneg_q[13] <= den[100];
      dmag13     <= den[100] ? 100'(-den) : den[99:0];
      nmag13     <= {3'd0, num_q[12], 42'd0};
    end
    if (rdy[14]) begin
      dmag14     <= dmag13;
      nmag14     <= nmag13;
      sh         <= 7'd100 - len;
      zero_q[14] <= (len == 7'd0);
    end
    if (rdy[15]) begin
      x0 <= xsh[99:70];
      y0 <= ysh[99:70];
    end
    for (int k = 14; k < 22; k++) begin
      if (rdy[k]) dneg_q[k] <= dneg_q[k-1];
    end
    for (int k = 15; k < 22; k++) begin
      if (rdy[k]) zero_q[k] <= zero_q[k-1];
    end
  end

  // stages 16..21: half angle
  logic signed [33:0] zang;

  sta_cordic u_cordic (.clk(clk), .en(rdy[21:16]), .x0(x0), .y0(y0), .z(zang));

  // stage 22: clamp, fold for a negative denominator, round to 16 fraction bits
  logic [32:0] zc, half, rsum;

  always_comb begin
    if (zang < 0) begin
      zc = '0;
    end else if (zang > $signed({1'b0, HALF_PI_Q30})) begin
      zc = HALF_PI_Q30;
    end else begin
      zc = zang[32:0];
    end
    half = dneg_q[21] ? PI_Q30 - zc : zc;
    rsum = half + ROUND_HALF;
  end

  always_ff @(posedge clk) begin
    if (rdy[OUT_STG]) begin
      solid_angle <= zero_q[21] ? 19'd0 : rsum[31:13];
    end
  end

`ifndef SYNTHESIS
  // results never exceed 2*pi
  a_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> solid_angle <= 19'd411775)
    else $error("solid angle above 2*pi");

  // input only backs up when the output register is full
  a_stall_src: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled with room in the pipeline");

  // at least one normalized CORDIC operand has its top bit set unless both are zero
  a_norm: assert property (@(posedge clk) disable iff (rst)
    vld[15] && !zero_q[15] |-> x0[29] || y0[29])
    else $error("CORDIC operands not normalized");

  // an unstalled full output stage hands its beat on
  a_drain: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_stall && !vld[OUT_STG-1] |=> !out_valid)
    else $error("output beat repeated");
`endif

endmodule

// ===== tb/sv/sta_checker.sv =====
// Scoreboard for spherical_triangle_solid_angle: predicts each triangle's solid angle and
// compares it with the output beats. Depends only on the block's port list.
module sta_checker (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic               in_stall,
  input  logic signed [17:0] a_x,
  input  logic signed [17:0] a_y,
  input  logic signed [17:0] a_z,
  input  logic signed [17:0] b_x,
  input  logic signed [17:0] b_y,
  input  logic signed [17:0] b_z,
  input  logic signed [17:0] c_x,
  input  logic signed [17:0] c_y,
  input  logic signed [17:0] c_z,
  input  logic               out_valid,
  input  logic               out_stall,
  input  logic [18:0]        solid_angle,
  output int                 fail_count,
  output int                 pending,
  output int                 checked
);

  localparam longint PI_Q30      = 64'd3373259426;
  localparam longint HALF_PI_Q30 = 64'd1686629713;

  logic [18:0] angle_q[$];

  // square root of v, rounded to nearest
  function automatic logic [63:0] root_rounded(input logic [63:0] v);
    logic [63:0] res;
    logic [63:0] bitv;
    res  = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v   = v - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return (v > res) ? res + 1 : res;
  endfunction

  function automatic longint arctan_q30(input int i);
    longint t[10] = '{843314856, 497837829, 263043836, 133525158, 67021686,
                      33543515, 16775850, 8388437, 4194282, 2097149};
    if (i < 10) return t[i];
    return (longint'(1) << (30 - i)) - 1;
  endfunction

  function automatic logic [18:0] solid_angle_of(input longint ax, ay, az, bx, by, bz,
                                                 cx, cy, cz);
    longint                kx, ky, kz, det, ab, ac, bc, x, y, z, xs, ys, half;
    logic [63:0]           na, nb, nc;
    logic signed [127:0]   den, dmag, nmag, mx;
    int                    len;
    logic                  dneg;
    kx  = ay * bz - az * by;
    ky  = az * bx - ax * bz;
    kz  = ax * by - ay * bx;
    det = kx * cx + ky * cy + kz * cz;
    if (det < 0) det = -det;
    na  = root_rounded(64'(ax * ax + ay * ay + az * az) << 28);
    nb  = root_rounded(64'(bx * bx + by * by + bz * bz) << 28);
    nc  = root_rounded(64'(cx * cx + cy * cy + cz * cz) << 28);
    ab  = ax * bx + ay * by + az * bz;
    ac  = ax * cx + ay * cy + az * cz;
    bc  = bx * cx + by * cy + bz * cz;
    // denominator with 42 fraction bits
    den = $signed({64'd0, na * nb}) * $signed({64'd0, nc});
    den = den + (($signed(128'(ab)) * $signed({64'd0, nc})) <<< 28);
    den = den + (($signed(128'(ac)) * $signed({64'd0, nb})) <<< 28);
    den = den + (($signed(128'(bc)) * $signed({64'd0, na})) <<< 28);
    dneg = den < 0;
    dmag = dneg ? -den : den;
    nmag = $signed(128'(det)) <<< 42;
    mx   = (dmag > nmag) ? dmag : nmag;
    len  = 0;
    for (int k = 0; k < 128; k++) if (mx[k]) len = k + 1;
    if (len == 0) return '0;
    // normalize the larger magnitude to 30 bits
    if (len > 30) begin
      dmag = dmag >> (len - 30);
      nmag = nmag >> (len - 30);
    end else begin
      dmag = dmag << (30 - len);
      nmag = nmag << (30 - len);
    end
    x = longint'(dmag);
    y = longint'(nmag);
    z = 0;
    // vectoring CORDIC
    for (int i = 0; i < 30; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y > 0) begin
        x = x + ys; y = y - xs; z = z + arctan_q30(i);
      end else begin
        x = x - ys; y = y + xs; z = z - arctan_q30(i);
      end
    end
    if (z < 0) z = 0;
    if (z > HALF_PI_Q30) z = HALF_PI_Q30;
    half = dneg ? PI_Q30 - z : z;
    return 19'((half + 4096) >> 13);
  endfunction

  task automatic report_mismatch(input string what);
    $display("MISMATCH at %0t: %s", $realtime, what);
    fail_count++;
  endtask

  initial begin
    fail_count = 0;
    checked    = 0;
  end

  assign pending = angle_q.size();

  // input beats make predictions, output beats are compared in order
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && !in_stall)
        angle_q.push_back(solid_angle_of(a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z));
      if (out_valid && !out_stall) begin
        if (angle_q.size() == 0) begin
          report_mismatch($sformatf("unexpected beat solid_angle=%0d", solid_angle));
        end else begin
          if (solid_angle !== angle_q[0])
            report_mismatch($sformatf("solid_angle got %0d want %0d", solid_angle,
                                      angle_q[0]));
          void'(angle_q.pop_front());
          checked++;
        end
      end
    end
  end

endmodule

// ===== tb/sv/tb_top.sv =====
// Testbench top for spherical_triangle_solid_angle: clock, reset, triangle stimulus and verdict.
// Depends on the RTL block and on sta_checker.
module tb_top;

  logic               clk = 0;
  logic               rst = 1;
  logic               in_valid = 0;
  logic               in_stall;
  logic signed [17:0] a_x = 0, a_y = 0, a_z = 0;
  logic signed [17:0] b_x = 0, b_y = 0, b_z = 0;
  logic signed [17:0] c_x = 0, c_y = 0, c_z = 0;
  logic               out_valid;
  logic               out_stall = 0;
  logic [18:0]        solid_angle;
  int                 fail_count, pending, checked;
  int                 sent = 0;
  bit                 no_idle = 0;

  always #1 clk = ~clk;

  spherical_triangle_solid_angle u_dut (.*);

  sta_checker u_chk (.*);

  // one triangle beat, held until accepted
  task automatic send_triangle(input int v[9]);
    logic stalled;
    if (!no_idle)
      while ($urandom_range(99) < 38) begin
        in_valid <= 0;
        @(posedge clk);
      end
    in_valid <= 1;
    a_x <= 18'(v[0]); a_y <= 18'(v[1]); a_z <= 18'(v[2]);
    b_x <= 18'(v[3]); b_y <= 18'(v[4]); b_z <= 18'(v[5]);
    c_x <= 18'(v[6]); c_y <= 18'(v[7]); c_z <= 18'(v[8]);
    do begin
      @(negedge clk) stalled = in_stall;
      @(posedge clk);
    end while (stalled);
    sent++;
  endtask

  function automatic int rnd_full();
    return int'($signed(18'($urandom)));
  endfunction

  function automatic int rnd_span(input int m);
    return $urandom_range(2 * m) - m;
  endfunction

  // output side: random stall, one long hold-off, and a quiet stretch
  initial begin
    int cyc;
    cyc = 0;
    @(negedge rst);
    forever begin
      @(posedge clk);
      cyc++;
      if (cyc >= 300 && cyc < 450) out_stall <= 1;
      else if (no_idle) out_stall <= 0;
      else out_stall <= ($urandom_range(99) < 38);
    end
  end

  initial begin
    #2000000;
    $display("Mismatches found");
    $finish;
  end

  initial begin
    int v[9];
    int lo, hi, u, sg;
    lo = -131072;
    hi = 131071;
    u  = 4096;
    repeat (10) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    // directed: degenerate, extremes, orthogonal, coplanar both signs
    send_triangle('{0, 0, 0, 0, 0, 0, 0, 0, 0});
    send_triangle('{0, 0, 0, u, 0, 0, 0, u, 0});
    send_triangle('{u, 0, 0, 0, u, 0, 0, 0, u});
    send_triangle('{u, 0, 0, 0, 0, u, 0, u, 0});
    send_triangle('{hi, hi, hi, lo, lo, lo, hi, lo, hi});
    send_triangle('{lo, lo, lo, lo, lo, lo, lo, lo, lo});
    send_triangle('{hi, 0, 0, 0, hi, 0, 0, 0, hi});
    send_triangle('{lo, 0, 0, 0, lo, 0, 0, 0, lo});
    send_triangle('{hi, lo, 0, lo, 0, hi, 0, hi, lo});
    send_triangle('{u, 0, 0, -u, u, 0, -u, -u, 0});
    send_triangle('{u, 0, 0, 0, u, 0, u, u, 0});
    send_triangle('{u, 0, 0, -u, 0, 0, 0, u, 0});
    send_triangle('{u, 0, 0, -u, 1, 0, 0, -1, u});
    send_triangle('{u, 1, 0, -u, 1, 0, -1, -u, 1});
    send_triangle('{1, 0, 0, 0, 1, 0, 0, 0, 1});
    send_triangle('{-1, -1, -1, 1, 1, 1, -1, 1, -1});
    send_triangle('{u, 0, 0, u, 0, 0, u, 0, 0});
    send_triangle('{u, u, 0, 0, u, u, u, 0, u});
    // sender waits for the pipe to drain
    in_valid <= 0;
    while (pending != 0) @(posedge clk);
    repeat (30) @(posedge clk);
    for (int n = 0; n < 500; n++) begin
      no_idle = (n >= 150 && n < 250);
      case ($urandom_range(3))
        0: foreach (v[k]) v[k] = rnd_full();
        1: foreach (v[k]) v[k] = rnd_span(u * 2);
        2: begin
          // coplanar triangle, third vertex on the plane of the first two
          sg = $urandom_range(1) ? 1 : -1;
          for (int k = 0; k < 6; k++) v[k] = rnd_span(32768);
          for (int k = 0; k < 3; k++)
            v[6 + k] = sg * (v[k] + v[3 + k]);
        end
        default: foreach (v[k]) v[k] = rnd_span(64);
      endcase
      send_triangle(v);
    end
    in_valid <= 0;
    while (pending != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    $display("Ran %0d triangles (%0d results compared): extremes, degenerate, coplanar,",
             sent, checked);
    $display("small and full-range vertices under random and long output stalls.");
    if (fail_count == 0 && pending == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

endmodule
